FILE: src/cmcg_pkg.sv
// Package for the Rule 30 mixed-charset character generator.
// State encoding, size constants and the charset lookup; no dependencies.

package cmcg_pkg;

    localparam int MAX_LEN_DEF  = 64;
    localparam int CFG_W        = 7;
    localparam int BYTE_W       = 8;
    localparam int CHAR_W       = 7;
    localparam int CFG_RESET    = 16;
    localparam int SYM_COUNT    = 74;
    localparam int ROT_LEFT     = 3;
    localparam int ROT_RIGHT    = BYTE_W - ROT_LEFT;
    localparam int PUNCT_FIRST  = 62;
    localparam int PUNCT_COUNT  = SYM_COUNT - PUNCT_FIRST;

    typedef enum logic [2:0] {
        S_LOAD,
        S_EVOLVE,
        S_RD0,
        S_RD1,
        S_RD2
    } t_state;

    // "!@#$%^&*()_+" in charset order
    localparam logic [CHAR_W-1:0] PUNCT [PUNCT_COUNT] = '{
        7'd33, 7'd64, 7'd35, 7'd36, 7'd37, 7'd94,
        7'd38, 7'd42, 7'd40, 7'd41, 7'd95, 7'd43
    };

    // Symbol index 0..73 to ASCII: a-z, A-Z, 0-9, then punctuation.
    function automatic logic [CHAR_W-1:0] f_symbol(input logic [CHAR_W-1:0] idx);
        logic [CHAR_W-1:0] p;
        logic [CHAR_W-1:0] sym;
        p = idx - CHAR_W'(PUNCT_FIRST);
        if (idx < CHAR_W'(26)) begin
            sym = idx + CHAR_W'(97);
        end else if (idx < CHAR_W'(52)) begin
            sym = idx - CHAR_W'(26) + CHAR_W'(65);
        end else if (idx < CHAR_W'(PUNCT_FIRST)) begin
            sym = idx - CHAR_W'(52) + CHAR_W'(48);
        end else if (p < CHAR_W'(PUNCT_COUNT)) begin
            sym = PUNCT[p[3:0]];
        end else begin
            sym = PUNCT[PUNCT_COUNT-1];
        end
        return sym;
    endfunction

endpackage

FILE: src/ca_mixed_charset_generator.sv
// Top level of the Rule 30 mixed-charset character generator.
// Uses cmcg_pkg, cmcg_ram (random bytes, automaton bits) and cmcg_mix.
//
// channel   direction  handshake               payload
// input     in         i_valid / o_stall       i_rand_byte
// output    out        o_valid / i_stall       o_out_char, o_last_char
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (out_length)
//
// Bytes load one per cycle while o_stall is low. The byte that completes a
// run of len bytes starts the automaton generations, one row step per cycle,
// then each character passes S_RD0, S_RD1 and S_RD2 through the single-read
// RAM ports, and an output stall holds S_RD2.
// Reset is synchronous, active low; no clearing pass is needed.
// o_stall is high after the completing byte until the last character is
// registered; a stalled output holds its character and freezes the emit loop.

module ca_mixed_charset_generator
    import cmcg_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rand_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_last_char,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);

    t_state             r_state, n_state;
    logic [LW-1:0]      r_cnt, n_cnt;
    logic [LW-1:0]      r_idx, n_idx;
    logic [MAX_LEN-1:0] r_row, n_row;
    logic [CFG_W-1:0]   r_cfg;
    logic [BYTE_W-1:0]  r_ra, n_ra;
    logic               r_ba, n_ba;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic               r_last, n_last;
    logic               r_valid, n_valid;

    logic [LW-1:0]      len;
    logic [LW-1:0]      cnt_inc;
    logic [LW-1:0]      idx_p1;
    logic [LW-1:0]      idx1;
    logic [LW:0]        idx2_t;
    logic [LW-1:0]      idx2;
    logic [MAX_LEN-1:0] row_mask;
    logic [MAX_LEN-1:0] row_init;
    logic [AW-1:0]      slot;
    logic               load_req;
    logic               out_free;
    logic [BYTE_W-1:0]  rnd_q;
    logic               bit_q;
    logic [CHAR_W-1:0]  mix_char;

    // effective run length, clamped to 1..MAX_LEN
    always_comb begin
        if (r_cfg == '0) begin
            len = LW'(1);
        end else if (r_cfg > CFG_W'(MAX_LEN)) begin
            len = LW'(MAX_LEN);
        end else begin
            len = LW'(r_cfg);
        end
    end

    always_comb begin
        cnt_inc = (r_cnt >= LW'(MAX_LEN)) ? r_cnt : r_cnt + LW'(1);
        slot    = (r_cnt >= LW'(MAX_LEN)) ? AW'(MAX_LEN - 1) : r_cnt[AW-1:0];
        idx_p1  = r_idx + LW'(1);
        idx1    = (idx_p1 == len) ? '0 : idx_p1;
        // second subtract covers a run length of one
        idx2_t  = {1'b0, r_idx} + (LW+1)'(2);
        if (idx2_t >= {1'b0, len}) idx2_t = idx2_t - {1'b0, len};
        if (idx2_t >= {1'b0, len}) idx2_t = idx2_t - {1'b0, len};
        idx2    = idx2_t[LW-1:0];
        for (int j = 0; j < MAX_LEN; j++) begin
            row_mask[j] = (LW'(j) < len);
            row_init[j] = (LW'(j) == (len >> 1));
        end
    end

    assign load_req = (r_state == S_LOAD) && i_valid;
    assign out_free = !r_valid || !i_stall;

    cmcg_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_rnd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (load_req),
        .i_wr_addr (slot),
        .i_wr_data (i_rand_byte),
        .i_rd_addr ((r_state == S_RD0) ? r_idx[AW-1:0] : idx2[AW-1:0]),
        .o_rd_data (rnd_q)
    );

    cmcg_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_bit_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_EVOLVE),
        .i_wr_addr (r_idx[AW-1:0]),
        .i_wr_data (r_row[r_idx[AW-1:0]]),
        .i_rd_addr ((r_state == S_RD0) ? r_idx[AW-1:0] : idx1[AW-1:0]),
        .o_rd_data (bit_q)
    );

    cmcg_mix u_mix (
        .i_rnd_a (r_ra),
        .i_bit_a (r_ba),
        .i_bit_b (bit_q),
        .i_rnd_b (rnd_q),
        .o_char  (mix_char)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_row      = r_row;
        n_ra       = r_ra;
        n_ba       = r_ba;
        n_out_char = r_out_char;
        n_last     = r_last;
        n_valid    = r_valid;
        if (r_valid && !i_stall) n_valid = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= len) begin
                        n_cnt   = '0;
                        n_idx   = '0;
                        n_row   = row_init;
                        n_state = S_EVOLVE;
                    end
                end
            end
            S_EVOLVE: begin
                // Rule 30: left ^ (center | right), zero outside the row
                n_row = ((r_row << 1) ^ (r_row | (r_row >> 1))) & row_mask;
                if (idx_p1 == len) begin
                    n_idx   = '0;
                    n_state = S_RD0;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_RD0: begin
                n_state = S_RD1;
            end
            S_RD1: begin
                n_ra    = rnd_q;
                n_ba    = bit_q;
                n_state = S_RD2;
            end
            S_RD2: begin
                // read addresses stay put while the output slot is busy
                if (out_free) begin
                    n_valid    = 1'b1;
                    n_out_char = mix_char;
                    n_last     = (idx_p1 == len);
                    if (idx_p1 == len) begin
                        n_idx   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = idx_p1;
                        n_state = S_RD0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_row   <= '0;
            r_cfg   <= CFG_W'(CFG_RESET);
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_row   <= n_row;
            r_valid <= n_valid;
            if (i_cfg_valid) r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra       <= n_ra;
        r_ba       <= n_ba;
        r_out_char <= n_out_char;
        r_last     <= n_last;
    end

    assign o_stall     = (r_state != S_LOAD);
    assign o_valid     = r_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: src/cmcg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module cmcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/cmcg_mix.sv
// Byte mixer: combines random bytes with automaton bits, rotates,
// reduces mod 74 and maps to a charset symbol. Uses cmcg_pkg.

module cmcg_mix
    import cmcg_pkg::*;
(
    input  logic [BYTE_W-1:0] i_rnd_a,
    input  logic              i_bit_a,
    input  logic              i_bit_b,
    input  logic [BYTE_W-1:0] i_rnd_b,
    output logic [CHAR_W-1:0] o_char
);

    logic [BYTE_W-1:0] mixed;
    logic [BYTE_W-1:0] rotated;
    logic [BYTE_W-1:0] red;

    always_comb begin
        mixed   = (i_rnd_a ^ BYTE_W'(i_bit_a)) + (i_bit_b ? i_rnd_b : '0);
        rotated = (mixed << ROT_LEFT) | (mixed >> ROT_RIGHT);
        // value < 256 < 4*74, so one subtract of the largest fitting multiple of 74 finishes the modulo
        red = rotated;
        if (red >= BYTE_W'(3 * SYM_COUNT)) begin
            red = red - BYTE_W'(3 * SYM_COUNT);
        end else if (red >= BYTE_W'(2 * SYM_COUNT)) begin
            red = red - BYTE_W'(2 * SYM_COUNT);
        end else if (red >= BYTE_W'(SYM_COUNT)) begin
            red = red - BYTE_W'(SYM_COUNT);
        end
        o_char = f_symbol(red[CHAR_W-1:0]);
    end

endmodule

FILE: src/cmcg_chk.sv
// Port-level checker for ca_mixed_charset_generator, bound to the top level.
// Uses cmcg_pkg for field widths.

module cmcg_chk
    import cmcg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [BYTE_W-1:0] i_rand_byte,
    input logic              o_valid,
    input logic              i_stall,
    input logic [CHAR_W-1:0] o_out_char,
    input logic              o_last_char
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_last_char))
        else $error("stalled output changed");

    // a character other than the last one means the run is still emitting
    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_char |-> o_stall)
        else $error("input open while a run is still emitting");

    // a stalled input request keeps its byte
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_rand_byte))
        else $error("stalled input request changed");

    // reset empties the output and opens the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

endmodule

bind ca_mixed_charset_generator cmcg_chk u_cmcg_chk (.*);
